// File: hw/rtl/byte_stuffed_frame_receiver_unit_defines.svh
// Assertion macros for the byte-stuffed frame receiver
`ifndef BYTE_STUFFED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define BSFR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bsfr_pkg.sv
// Types and constants shared by the byte-stuffed frame receiver
`default_nettype none

package bsfr_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7e;
   localparam logic [7:0] ESC_BYTE  = 8'h7d;
   localparam logic [7:0] ESC_FLAG  = 8'h5e;
   localparam logic [7:0] ESC_ESC   = 8'h5d;

   localparam int STORE_DEPTH = 7;
   localparam int COUNT_W     = 3;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(STORE_DEPTH);
   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(STORE_DEPTH - 1);

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [7:0]  motor_number;
      logic        short_frame;
      logic        overflow;
   } bsfr_result_type;

   typedef struct packed {
      logic            emit;
      logic            in_frame;
      bsfr_result_type res;
   } bsfr_event_type;

endpackage

`default_nettype wire

// File: hw/rtl/byte_stuffed_frame_receiver_unit.sv
// rsp_valid rises once the closing flag beat has passed the byte register and been loaded into the result register.
// Throughput: one byte beat per cycle; one register stage per side, no iteration.
// The byte register is stalled only while a result sits unread under rsp_stall.
// Reset (synchronous): idle, no escape, count and overflow cleared, store zeroed.
// Top level of the byte-stuffed frame receiver
`default_nettype none

module byte_stuffed_frame_receiver_unit
   import bsfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_gain_p,
   output logic [15:0]      rsp_gain_i,
   output logic [15:0]      rsp_gain_d,
   output logic [7:0]       rsp_motor_number,
   output logic             rsp_short_frame,
   output logic             rsp_overflow
);

   logic            in_vld_ff, in_vld_in;
   logic [7:0]      in_byte_ff;
   logic            go;
   logic            req_take;
   bsfr_event_type  evt;
   bsfr_result_type rsp_res;

   // advance the byte register unless a result is waiting and stalled
   assign go        = in_vld_ff && !(rsp_valid && rsp_stall);
   assign req_stall = in_vld_ff && !go;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   bsfr_deframer u_deframer (
      .clock   (clock),
      .reset   (reset),
      .go      (go),
      .rx_byte (in_byte_ff),
      .evt     (evt)
   );

   bsfr_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .evt       (evt),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res)
   );

   assign rsp_gain_p       = rsp_res.gain_p;
   assign rsp_gain_i       = rsp_res.gain_i;
   assign rsp_gain_d       = rsp_res.gain_d;
   assign rsp_motor_number = rsp_res.motor_number;
   assign rsp_short_frame  = rsp_res.short_frame;
   assign rsp_overflow     = rsp_res.overflow;

`include "byte_stuffed_frame_receiver_unit_defines.svh"

   `BSFR_ASSERT_ALWAYS(a_ovf_not_short, !(rsp_valid && rsp_overflow && rsp_short_frame), "overflow result flagged short")
   `BSFR_ASSERT_ALWAYS(a_stall_cause, !req_stall || (rsp_valid && rsp_stall), "input stalled without a held result")
   `BSFR_ASSERT_NEXT(a_idle_after_close, go && evt.emit, !evt.in_frame && rsp_valid, "frame not closed after result")

endmodule

`default_nettype wire

// File: hw/rtl/bsfr_deframer.sv
// Frame state, escape removal and the seven-byte payload store
`default_nettype none

module bsfr_deframer
   import bsfr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           go,
   input  wire logic [7:0]     rx_byte,
   output bsfr_event_type      evt
);

   logic                in_frame_ff, in_frame_in;
   logic                escape_ff, escape_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [7:0]          store_ff [STORE_DEPTH];
   logic [7:0]          store_in [STORE_DEPTH];

   logic                put0, put1;
   logic [7:0]          put0_data, put1_data;
   logic                emit;

   always_comb begin
      in_frame_in = in_frame_ff;
      escape_in   = escape_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      put0        = 1'b0;
      put1        = 1'b0;
      put0_data   = rx_byte;
      put1_data   = rx_byte;
      emit        = 1'b0;

      if (!in_frame_ff) begin
         if (rx_byte == FLAG_BYTE) begin
            in_frame_in = 1'b1;
            escape_in   = 1'b0;
            count_in    = '0;
            ovf_in      = 1'b0;
         end
      end else if (rx_byte == FLAG_BYTE) begin
         emit        = 1'b1;
         in_frame_in = 1'b0;
         escape_in   = 1'b0;
         count_in    = '0;
         ovf_in      = 1'b0;
      end else if (rx_byte == ESC_BYTE) begin
         escape_in = 1'b1;
      end else if (escape_ff) begin
         escape_in = 1'b0;
         put0      = 1'b1;
         case (rx_byte)
            ESC_FLAG: put0_data = FLAG_BYTE;
            ESC_ESC:  put0_data = ESC_BYTE;
            default: begin
               // unknown escape: keep the escape byte and the byte after it
               put0_data = ESC_BYTE;
               put1      = 1'b1;
            end
         endcase
      end else begin
         put0 = 1'b1;
      end

      // saturate the count at the store depth, flag anything dropped
      if (put1) begin
         count_in = (count_ff >= COUNT_LAST) ? COUNT_FULL : count_ff + COUNT_W'(2);
         if (count_ff >= COUNT_LAST) begin
            ovf_in = 1'b1;
         end
      end else if (put0) begin
         count_in = (count_ff == COUNT_FULL) ? COUNT_FULL : count_ff + COUNT_W'(1);
         if (count_ff == COUNT_FULL) begin
            ovf_in = 1'b1;
         end
      end

      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_in[i] = store_ff[i];
         if (put0 && count_ff == COUNT_W'(i)) begin
            store_in[i] = put0_data;
         end
         if (put1 && count_ff != COUNT_FULL && count_ff + COUNT_W'(1) == COUNT_W'(i)) begin
            store_in[i] = put1_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         escape_ff   <= 1'b0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else if (go) begin
         in_frame_ff <= in_frame_in;
         escape_ff   <= escape_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= store_in[i];
         end
      end
   end

   always_comb begin
      evt.emit             = emit;
      evt.in_frame         = in_frame_ff;
      evt.res.gain_p       = {store_ff[1], store_ff[0]};
      evt.res.gain_i       = {store_ff[3], store_ff[2]};
      evt.res.gain_d       = {store_ff[5], store_ff[4]};
      evt.res.motor_number = store_ff[6];
      evt.res.short_frame  = (count_ff != COUNT_FULL);
      evt.res.overflow     = ovf_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/bsfr_rsp_reg.sv
// Result register that holds a frame result until the consumer takes it
`default_nettype none

module bsfr_rsp_reg
   import bsfr_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           go,
   input  wire bsfr_event_type evt,
   input  wire logic           rsp_stall,
   output logic                rsp_valid,
   output bsfr_result_type     rsp_res
);

   logic            vld_ff, vld_in;
   logic            load;
   bsfr_result_type res_ff;

   assign load   = go && evt.emit;
   assign vld_in = load || (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= evt.res;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_res   = res_ff;

endmodule

`default_nettype wire
